FILE: rtl/core/bni_pkg.sv
// ----------------------------------------------------------------------------
// bni_pkg: shared types and constants for batch normalization inference
// Payload structs, command codes and front/back queue entry type.
// ----------------------------------------------------------------------------
package bni_pkg;

  localparam int DATA_W = 16;
  localparam int CH_W   = 6;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_DATA = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    REG_CHANNEL_COUNT = 1'b0,
    REG_EPSILON       = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic              cmd;
    logic [CH_W-1:0]   load_channel;
    logic signed [15:0] gamma_value;
    logic signed [15:0] beta_value;
    logic signed [15:0] mean_value;
    logic [15:0]       variance_value;
    logic signed [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] result;
    logic [CH_W-1:0]   result_channel;
    logic              saturated;
  } out_item_t;

  // Work item handed from front to back: operands already fetched.
  typedef struct packed {
    logic signed [15:0] gamma;
    logic signed [15:0] beta;
    logic signed [15:0] mean;
    logic [16:0]       vsum;
    logic signed [15:0] sample;
    logic [CH_W-1:0]   channel;
  } work_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } back_state_t;

endpackage

FILE: rtl/core/bni_ram.sv
// ----------------------------------------------------------------------------
// bni_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bni_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: rtl/core/bni_front.sv
// ----------------------------------------------------------------------------
// bni_front: command decode, channel counter and table access
// Loads write tables; samples fetch parameters and push a work item.
// ----------------------------------------------------------------------------
module bni_front #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [6:0]        channel_count,
  input  logic [15:0]       epsilon,
  input  logic              in_valid,
  output logic              in_ready,
  input  bni_pkg::in_item_t in_item,
  output logic              wq_valid,
  input  logic              wq_ready,
  output bni_pkg::work_t    wq_item
);
  import bni_pkg::*;

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW = $clog2(MAX_CHANNELS + 1) > 7 ? $clog2(MAX_CHANNELS + 1) : 7;

  logic [AW-1:0] counter;
  logic [AW-1:0] counter_next;
  logic [AW-1:0] raddr;      // effective channel of this sample
  logic [CW-1:0] active;
  logic          pend;       // read issued, data lands next cycle
  logic [AW-1:0] pend_ch;
  logic [15:0]   pend_sample;
  logic          hold;       // work item waiting for the queue
  work_t         hold_item;
  logic          accept;
  logic          is_load;
  logic          is_data;
  logic          wr_ok;
  logic [15:0]   g_rd, b_rd, m_rd, v_rd;
  logic [AW-1:0] waddr;
  logic [CH_W:0] wide_lc;

  always_comb begin
    if (channel_count == 7'd0) begin
      active = CW'(1);
    end else if (CW'(channel_count) > CW'(MAX_CHANNELS)) begin
      active = CW'(MAX_CHANNELS);
    end else begin
      active = CW'(channel_count);
    end
  end

  // Only one sample in flight in the front; stall while holding.
  assign in_ready = !pend && !hold;
  assign accept   = in_valid && in_ready;
  assign is_load  = accept && (in_item.cmd == CMD_LOAD);
  assign is_data  = accept && (in_item.cmd == CMD_DATA);
  assign wide_lc  = {1'b0, in_item.load_channel};
  assign wr_ok    = is_load && ((CH_W+1 > CW ? (CH_W+1)'(wide_lc) : CW'(wide_lc))
                    < (CH_W+1 > CW ? (CH_W+1)'(MAX_CHANNELS) : CW'(MAX_CHANNELS)));
  assign waddr    = AW'(in_item.load_channel);

  // counter may exceed a shrunk channel count: wrap to zero first
  assign raddr = (CW'(counter) >= active) ? '0 : counter;

  always_comb begin
    if (CW'(raddr) + CW'(1) >= active) begin
      counter_next = '0;
    end else begin
      counter_next = raddr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      pend    <= 1'b0;
      hold    <= 1'b0;
    end else begin
      if (is_load) begin
        counter <= '0;
      end else if (is_data) begin
        counter <= counter_next;
      end
      pend <= is_data;
      if (pend && !wq_ready) begin
        hold <= 1'b1;
      end else if (hold && wq_ready) begin
        hold <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_data) begin
      pend_ch     <= raddr;
      pend_sample <= in_item.sample;
    end
    if (pend && !wq_ready) begin
      hold_item <= wq_item;
    end
  end

  bni_ram #(.WIDTH(16), .DEPTH(MAX_CHANNELS)) u_gamma (
    .clk, .we(wr_ok), .waddr, .wdata(in_item.gamma_value),
    .re(is_data), .raddr, .rdata(g_rd));
  bni_ram #(.WIDTH(16), .DEPTH(MAX_CHANNELS)) u_beta (
    .clk, .we(wr_ok), .waddr, .wdata(in_item.beta_value),
    .re(is_data), .raddr, .rdata(b_rd));
  bni_ram #(.WIDTH(16), .DEPTH(MAX_CHANNELS)) u_mean (
    .clk, .we(wr_ok), .waddr, .wdata(in_item.mean_value),
    .re(is_data), .raddr, .rdata(m_rd));
  bni_ram #(.WIDTH(16), .DEPTH(MAX_CHANNELS)) u_var (
    .clk, .we(wr_ok), .waddr, .wdata(in_item.variance_value),
    .re(is_data), .raddr, .rdata(v_rd));

  always_comb begin
    if (hold) begin
      wq_item = hold_item;
    end else begin
      wq_item.gamma   = g_rd;
      wq_item.beta    = b_rd;
      wq_item.mean    = m_rd;
      wq_item.vsum    = {1'b0, v_rd} + {1'b0, epsilon};
      wq_item.sample  = pend_sample;
      wq_item.channel = CH_W'(pend_ch);
    end
  end
  assign wq_valid = pend || hold;

  assert property (@(posedge clk) disable iff (rst) !(pend && hold))
    else $error("front: pending read overlaps held item");
  assert property (@(posedge clk) disable iff (rst)
    (CW'(counter) < CW'(MAX_CHANNELS)))
    else $error("front: channel counter out of range");
  assert property (@(posedge clk) disable iff (rst) hold && !wq_ready |=> hold)
    else $error("front: held item dropped");
endmodule

FILE: rtl/core/bni_queue.sv
// ----------------------------------------------------------------------------
// bni_queue: two-entry FIFO between front and back
// Lets the front keep fetching while the back works.
// ----------------------------------------------------------------------------
module bni_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bni_pkg::work_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output bni_pkg::work_t out_item
);
  import bni_pkg::*;

  work_t      slots [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_item;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue: count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> (wptr == rptr))
    else $error("queue: pointers disagree with empty count");
  assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("queue: push lost");
endmodule

FILE: rtl/core/bni_back.sv
// ----------------------------------------------------------------------------
// bni_back: square root, divide and saturate for one work item
// Bit-serial root (13 steps) then restoring divide (33 steps).
// ----------------------------------------------------------------------------
module bni_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                wq_valid,
  output logic                wq_ready,
  input  bni_pkg::work_t      wq_item,
  output logic                out_valid,
  input  logic                out_ready,
  output bni_pkg::out_item_t  out_item
);
  import bni_pkg::*;

  back_state_t state, state_next;
  work_t       w;
  logic [24:0] rad;      // remaining radicand
  logic [25:0] root;     // partial root; final value fits in 13 bits
  logic [25:0] rbit;     // one-hot test bit of the root loop
  logic [3:0]  step;
  logic [5:0]  dstep;
  logic signed [16:0] d;
  logic [32:0] pmag;
  logic        pneg;
  logic [32:0] quo;
  logic [13:0] rem;
  logic [13:0] rem_sh;
  logic [25:0] trial;
  logic signed [34:0] rsum;
  logic signed [31:0] prod;

  // sqrt(s<<8): radicand up to 25 bits, partial root up to 26 bits
  assign trial  = root + {1'b0, rbit[24:0]};
  assign rem_sh = {rem[12:0], quo[32]};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (wq_valid) state_next = ST_SQRT;
      ST_SQRT: if (step == 4'd12) state_next = ST_DIV;
      ST_DIV:  if (dstep == 6'd33 || root == 26'd0) state_next = ST_FIX;
      ST_FIX:  state_next = ST_OUT;
      ST_OUT:  if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    wq_ready  = state == ST_IDLE;
    out_valid = state == ST_OUT;
  end

  assign d    = 17'(w.sample) - 17'(w.mean);
  assign prod = 32'(w.gamma) * 32'(d);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (wq_valid) begin
          w    <= wq_item;
          rad  <= {wq_item.vsum, 8'd0};
          root <= '0;
          rbit <= 26'(1) << 24;
          step <= '0;
        end
      end
      ST_SQRT: begin
        if ({1'b0, rad} >= trial) begin
          rad  <= 25'({1'b0, rad} - trial);
          root <= (root >> 1) + {1'b0, rbit[24:0]};
        end else begin
          root <= root >> 1;
        end
        rbit <= rbit >> 2;
        step <= step + 4'd1;
        if (step == 4'd0) begin
          pneg <= prod[31];
        end
        // product magnitude registered for the divide
        pmag  <= prod[31] ? 33'(-33'(prod)) : 33'(prod);
        dstep <= '0;
        rem   <= '0;
      end
      ST_DIV: begin
        if (dstep == 6'd0) begin
          quo <= pmag;
        end
        if (dstep != 6'd0) begin
          if (rem_sh >= {1'b0, root[12:0]}) begin
            rem <= rem_sh - {1'b0, root[12:0]};
            quo <= {quo[31:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[31:0], 1'b0};
          end
        end
        dstep <= dstep + 6'd1;
      end
      ST_FIX: begin
        if (root == 26'd0) begin
          if (pmag == '0) begin
            out_item.result    <= w.beta;
            out_item.saturated <= 1'b0;
          end else begin
            out_item.result    <= pneg ? 16'sh8000 : 16'sh7fff;
            out_item.saturated <= 1'b1;
          end
        end else if (rsum > 35'sd32767) begin
          out_item.result    <= 16'sh7fff;
          out_item.saturated <= 1'b1;
        end else if (rsum < -35'sd32768) begin
          out_item.result    <= 16'sh8000;
          out_item.saturated <= 1'b1;
        end else begin
          out_item.result    <= 16'(rsum);
          out_item.saturated <= 1'b0;
        end
        out_item.result_channel <= w.channel;
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  // quotient sign restored, then offset added
  assign rsum = (pneg ? -$signed({2'b00, quo}) : $signed({2'b00, quo})) + 35'(w.beta);

  assert property (@(posedge clk) disable iff (rst) !(wq_ready && out_valid))
    else $error("back: idle and presenting at once");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("back: result changed while stalled");
endmodule

FILE: rtl/core/batch_norm_inference.sv
// ----------------------------------------------------------------------------
// batch_norm_inference: per-channel batch normalization, signed Q8.8
// Loads fill the parameter tables; samples are normalized and saturated.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one transaction per item. cmd
//   selects a parameter load (writes gamma, beta, mean, variance of
//   load_channel and restarts the channel count) or a data sample.
//   Each sample gives one output transaction on out_valid/out_ready:
//   gamma*(sample-mean)/sqrt(variance+epsilon)+beta, saturated to 16 bits.
//   Config writes (cfg_we, cfg_index, cfg_data) set channel_count and
//   epsilon; write them only while the block is idle.
//   After a sample the front accepts no new item until its table read is
//   done and the work item has left the front. A sample occupies the shared
//   back-end unit through a take step, 13 square-root steps, the divide
//   (operand load plus 33 steps), a saturate step and the output step; when
//   the root is zero the divide ends at its operand load. The front queues
//   up to two samples (plus one held) ahead of it. The back end takes no
//   new sample until its current result has been taken.
//   Reset clears the channel counter, queue and control, sets
//   channel_count=1 and epsilon=1; tables are undefined until loaded.
//   A stalled receiver holds the result; the queue then fills and
//   in_ready drops.
// ----------------------------------------------------------------------------
module batch_norm_inference #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  bni_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output bni_pkg::out_item_t out_item
);
  import bni_pkg::*;

  logic [6:0]  channel_count;
  logic [15:0] epsilon;
  logic        fq_valid, fq_ready, qb_valid, qb_ready;
  work_t       fq_item, qb_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 7'd1;
      epsilon       <= 16'd1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CHANNEL_COUNT: channel_count <= cfg_data[6:0];
        REG_EPSILON:       epsilon       <= cfg_data;
        default: ;
      endcase
    end
  end

  bni_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk, .rst, .channel_count, .epsilon,
    .in_valid, .in_ready, .in_item,
    .wq_valid(fq_valid), .wq_ready(fq_ready), .wq_item(fq_item));

  bni_queue u_queue (
    .clk, .rst,
    .in_valid(fq_valid), .in_ready(fq_ready), .in_item(fq_item),
    .out_valid(qb_valid), .out_ready(qb_ready), .out_item(qb_item));

  bni_back u_back (
    .clk, .rst,
    .wq_valid(qb_valid), .wq_ready(qb_ready), .wq_item(qb_item),
    .out_valid, .out_ready, .out_item);

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.result_channel < CH_W'(MAX_CHANNELS - 1) + 1'b1)
                  || (MAX_CHANNELS >= 64))
    else $error("top: result channel out of range");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.saturated |->
      (out_item.result == 16'sh7fff || out_item.result == 16'sh8000))
    else $error("top: saturation flag without clamped value");
  assert property (@(posedge clk) disable iff (rst)
    $rose(rst) |=> channel_count == 7'd1)
    else $error("top: reset value of channel count");
endmodule
